// ----- rtl/core/page_free_list_allocator_top_defines.svh -----
// ----------------------------------------------------------------------------
// page free list allocator assertion macros
// shared concurrent assertion forms, sampled on clk, off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef PAGE_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH
`define PAGE_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define PFLA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfla check failed");

// next-cycle implication
`define PFLA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfla check failed");

`endif

// ----- rtl/core/pfla_pkg.sv -----
// ----------------------------------------------------------------------------
// pfla_pkg
// shared types and codes of the page free list allocator
// ----------------------------------------------------------------------------
`default_nettype none

package pfla_pkg;

    localparam int ADDR_W   = 32;
    localparam int CFG_W    = 13;
    localparam int STATUS_W = 2;
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W = 1;

    // operation carried in tuser
    typedef enum logic [OP_W-1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_DOUBLE = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PAGES  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERN_RESERVE = 1'd1;

    // control sequencer
    typedef enum logic [2:0] {
        FSM_IDLE = 3'b001,
        FSM_INIT = 3'b010,
        FSM_EXEC = 3'b100
    } fsm_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   alloc_address;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/pfla_out_stage.sv -----
// ----------------------------------------------------------------------------
// pfla_out_stage
// result register between the allocator core and the master stream
// ----------------------------------------------------------------------------
`default_nettype none

module pfla_out_stage
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              res_valid,
    output logic                                   res_ready,
    input  wire pfla_pkg::result_t                 res,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [pfla_pkg::ADDR_W-1:0]            m_axis_tdata,   // alloc_address
    output logic [pfla_pkg::STATUS_W-1:0]          m_axis_tuser    // status
);

    logic              valid_reg;
    logic              valid_next;
    pfla_pkg::result_t data_reg;

    // room when empty or the held transaction leaves this cycle
    assign res_ready  = !valid_reg || m_axis_tready;
    assign valid_next = res_valid || (valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            data_reg <= res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg.alloc_address;
    assign m_axis_tuser  = data_reg.status;

endmodule

`default_nettype wire

// ----- rtl/core/page_free_list_allocator_top.sv -----
// ----------------------------------------------------------------------------
// page_free_list_allocator_top
// page frame allocator with a fifo free list held in block memory
// ----------------------------------------------------------------------------
// alloc, free and no-op: one synchronous read of the queue and mark memories,
//   then the write-back and result register load; a new request is taken only
//   once the result has gone to the output register
// init: walks every page once, then posts its result
// reset: asynchronous, active low; pool empty, no page marked, config at
//   a total of 4096 pages and no kernel reserve; no memory clearing pass is needed
// ----------------------------------------------------------------------------
`default_nettype none

module page_free_list_allocator_top #(
    parameter int MAX_PAGES  = 4096,   // queue and mark memory depth, 2 .. 65536
    parameter int PAGE_BYTES = 4096    // page size, a power of two, 256 .. 65536
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // request stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [pfla_pkg::ADDR_W-1:0]       s_axis_tdata,   // page_address
    input  wire logic [pfla_pkg::OP_W-1:0]         s_axis_tuser,   // op
    // result stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [pfla_pkg::ADDR_W-1:0]            m_axis_tdata,   // alloc_address
    output logic [pfla_pkg::STATUS_W-1:0]          m_axis_tuser,   // status
    // configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pfla_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pfla_pkg::CFG_W-1:0]        cfg_data
);

    // ------------------------------------------------------------------------
    // derived sizes
    // ------------------------------------------------------------------------
    localparam int PAGE_W = $clog2(MAX_PAGES);          // queue entry / mark index
    localparam int CNT_W  = $clog2(MAX_PAGES + 1);      // free count, holds full depth
    localparam int OFFS_W = $clog2(PAGE_BYTES);         // byte offset inside a page
    localparam int PIDX_W = pfla_pkg::ADDR_W - OFFS_W;  // page number of a full address
    localparam int FULL_W = PAGE_W + OFFS_W;            // page index shifted to bytes

    localparam logic [PAGE_W-1:0] LAST_PAGE  = PAGE_W'(MAX_PAGES - 1);
    localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(MAX_PAGES);

    // ------------------------------------------------------------------------
    // configuration registers, always ready
    // ------------------------------------------------------------------------
    logic [pfla_pkg::CFG_W-1:0] total_pages_reg;
    logic [pfla_pkg::CFG_W-1:0] kern_rsv_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_pages_reg <= pfla_pkg::CFG_W'(4096);
            kern_rsv_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                pfla_pkg::REG_TOTAL_PAGES:  total_pages_reg <= cfg_data;
                pfla_pkg::REG_KERN_RESERVE: kern_rsv_reg    <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // total clamped to the memory depth, kernel clamped to that total
    logic [CNT_W-1:0] total_eff;
    logic [CNT_W-1:0] kern_eff;

    assign total_eff = (32'(total_pages_reg) > 32'(MAX_PAGES)) ? FULL_COUNT
                                                               : CNT_W'(total_pages_reg);
    assign kern_eff  = (32'(kern_rsv_reg) < 32'(total_eff)) ? CNT_W'(kern_rsv_reg)
                                                            : total_eff;

    // ------------------------------------------------------------------------
    // control and pool state
    // ------------------------------------------------------------------------
    pfla_pkg::fsm_t    state_reg,     state_next;
    pfla_pkg::op_t     op_reg,        op_next;
    logic [PIDX_W-1:0] page_reg,      page_next;      // page number of a free request
    logic [PAGE_W-1:0] head_reg,      head_next;
    logic [PAGE_W-1:0] tail_reg,      tail_next;
    logic [CNT_W-1:0]  count_reg,     count_next;
    logic [PAGE_W-1:0] walk_reg,      walk_next;      // init sweep position
    logic              init_done_reg, init_done_next; // marks are valid only after init

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfla_pkg::FSM_IDLE;
            op_reg        <= pfla_pkg::OP_NOP;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            walk_reg      <= '0;
            init_done_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            walk_reg      <= walk_next;
            init_done_reg <= init_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
    end

    // ------------------------------------------------------------------------
    // free queue and allocated marks, one write and one read port each
    // ------------------------------------------------------------------------
    logic [PAGE_W-1:0] queue_mem [MAX_PAGES];
    logic              mark_mem  [MAX_PAGES];

    logic              rd_en;
    logic [PAGE_W-1:0] mark_raddr;
    logic [PAGE_W-1:0] q_rdata_reg;
    logic              mark_rdata_reg;

    logic              q_we;
    logic [PAGE_W-1:0] q_waddr;
    logic [PAGE_W-1:0] q_wdata;
    logic              mark_we;
    logic [PAGE_W-1:0] mark_waddr;
    logic              mark_wdata;

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            queue_mem[q_waddr] <= q_wdata;
        end
        if (rd_en)
        begin
            q_rdata_reg <= queue_mem[head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        if (rd_en)
        begin
            mark_rdata_reg <= mark_mem[mark_raddr];
        end
    end

    // ------------------------------------------------------------------------
    // result path
    // ------------------------------------------------------------------------
    pfla_pkg::result_t res;
    logic              res_valid;
    logic              res_ready;

    pfla_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------
    function automatic logic [PAGE_W-1:0] ptr_inc(input logic [PAGE_W-1:0] ptr);
        ptr_inc = (ptr == LAST_PAGE) ? '0 : ptr + 1'b1;
    endfunction

    pfla_pkg::op_t     op_in;
    logic [PIDX_W-1:0] page_in;
    logic [FULL_W-1:0] alloc_full;
    logic              walk_kern;     // sweep position reserved for the kernel
    logic              walk_in_pool;  // sweep position below the total
    logic              free_range_bad;
    logic              free_mark_set;

    assign op_in          = pfla_pkg::op_t'(s_axis_tuser);
    assign page_in        = s_axis_tdata[pfla_pkg::ADDR_W-1:OFFS_W];
    assign alloc_full     = {q_rdata_reg, {OFFS_W{1'b0}}};
    assign walk_kern      = 32'(walk_reg) < 32'(kern_eff);
    assign walk_in_pool   = 32'(walk_reg) < 32'(total_eff);
    assign free_range_bad = 32'(page_reg) >= 32'(total_eff);
    // marks from before the first init read as clear
    assign free_mark_set  = mark_rdata_reg && init_done_reg;

    // ------------------------------------------------------------------------
    // sequencer: accept and read memory, or sweep the pages for an init, then write back and post the result
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        page_next      = page_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        walk_next      = walk_reg;
        init_done_next = init_done_reg;

        s_axis_tready  = 1'b0;
        rd_en          = 1'b0;
        mark_raddr     = page_in[PAGE_W-1:0];

        q_we           = 1'b0;
        q_waddr        = tail_reg;
        q_wdata        = page_reg[PAGE_W-1:0];
        mark_we        = 1'b0;
        mark_waddr     = page_reg[PAGE_W-1:0];
        mark_wdata     = 1'b0;

        res_valid         = 1'b0;
        res.status        = pfla_pkg::STATUS_OK;
        res.alloc_address = '0;

        case (state_reg)
            pfla_pkg::FSM_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    // both reads issued, only the one the op needs is used
                    rd_en     = 1'b1;
                    op_next   = op_in;
                    page_next = page_in;
                    if (op_in == pfla_pkg::OP_INIT)
                    begin
                        head_next      = '0;
                        tail_next      = '0;
                        count_next     = '0;
                        walk_next      = '0;
                        init_done_next = 1'b1;
                        state_next     = pfla_pkg::FSM_INIT;
                    end
                    else
                    begin
                        state_next = pfla_pkg::FSM_EXEC;
                    end
                end
            end

            pfla_pkg::FSM_INIT:
            begin
                // every entry gets its mark, pool pages go to the tail in order
                mark_we    = 1'b1;
                mark_waddr = walk_reg;
                mark_wdata = walk_kern;
                if (!walk_kern && walk_in_pool)
                begin
                    q_we       = 1'b1;
                    q_waddr    = tail_reg;
                    q_wdata    = walk_reg;
                    tail_next  = ptr_inc(tail_reg);
                    count_next = count_reg + 1'b1;
                end
                if (walk_reg == LAST_PAGE)
                begin
                    state_next = pfla_pkg::FSM_EXEC;
                end
                else
                begin
                    walk_next = walk_reg + 1'b1;
                end
            end

            pfla_pkg::FSM_EXEC:
            begin
                res_valid = 1'b1;
                case (op_reg)
                    pfla_pkg::OP_ALLOC:
                    begin
                        if (count_reg == '0)
                        begin
                            res.status = pfla_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            res.alloc_address = pfla_pkg::ADDR_W'(alloc_full);
                            if (res_ready)
                            begin
                                mark_we    = 1'b1;
                                mark_waddr = q_rdata_reg;
                                mark_wdata = 1'b1;
                                head_next  = ptr_inc(head_reg);
                                count_next = count_reg - 1'b1;
                            end
                        end
                    end

                    pfla_pkg::OP_FREE:
                    begin
                        if (free_range_bad)
                        begin
                            res.status = pfla_pkg::STATUS_RANGE;
                        end
                        else if (!free_mark_set || count_reg == FULL_COUNT)
                        begin
                            res.status = pfla_pkg::STATUS_DOUBLE;
                        end
                        else if (res_ready)
                        begin
                            mark_we    = 1'b1;
                            mark_wdata = 1'b0;
                            q_we       = 1'b1;
                            tail_next  = ptr_inc(tail_reg);
                            count_next = count_reg + 1'b1;
                        end
                    end

                    default:
                    begin
                        // init completion and the reserved op report ok, address zero
                    end
                endcase
                if (res_ready)
                begin
                    state_next = pfla_pkg::FSM_IDLE;
                end
            end

            default:
            begin
                state_next = pfla_pkg::FSM_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/pfla_checker.sv -----
// ----------------------------------------------------------------------------
// pfla_checker
// port level checks of the page free list allocator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "page_free_list_allocator_top_defines.svh"

module pfla_checker #(
    parameter int PAGE_BYTES = 4096
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    input  wire logic                              s_axis_tready,
    input  wire logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic [pfla_pkg::ADDR_W-1:0]       m_axis_tdata,
    input  wire logic [pfla_pkg::STATUS_W-1:0]     m_axis_tuser
);

    localparam logic [pfla_pkg::ADDR_W-1:0] OFFS_MASK = pfla_pkg::ADDR_W'(PAGE_BYTES - 1);

    // a stalled result transaction holds
    `PFLA_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // failed requests never carry an address
    `PFLA_ASSERT_IMP(a_err_zero_addr,
                     m_axis_tvalid && m_axis_tuser != pfla_pkg::STATUS_OK,
                     m_axis_tdata == '0)

    // returned addresses are page aligned
    `PFLA_ASSERT_IMP(a_addr_aligned, m_axis_tvalid, (m_axis_tdata & OFFS_MASK) == '0)

    // requests are taken only while idle, so the slave side drops after a take
    `PFLA_ASSERT_NXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind page_free_list_allocator_top pfla_checker #(
    .PAGE_BYTES (PAGE_BYTES)
) u_pfla_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
